// ===== sv/ssrt_pkg.sv =====
// Shared types and constants for the sorted sparse route table.
package ssrt_pkg;

  localparam int unsigned CmdW    = 3;
  localparam int unsigned StatusW = 3;
  localparam int unsigned DistW   = 31;
  localparam int unsigned PortCityW = 16;
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 72;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD     = 3'd0,
    CMD_REMOVE  = 3'd1,
    CMD_FIND    = 3'd2,
    CMD_IT_FIRST = 3'd3,
    CMD_IT_NEXT = 3'd4,
    CMD_CLEAR   = 3'd5
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK     = 3'd0,
    ST_DUP    = 3'd1,
    ST_ABSENT = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_FULL   = 3'd4
  } status_e;

  // Row-wide control broadcast to every cell.
  typedef struct packed {
    logic load;  // capture compare flags against the incoming key
    logic ins;   // open a slot at the insert point and shift right
    logic del;   // close the slot at the hit point and shift left
  } cell_ctrl_t;

endpackage

// ===== sv/ssrt_cell.sv =====
// One sorted cell: holds an entry, compares it, and shifts with its neighbors.
module ssrt_cell #(
  parameter int unsigned KEY_W = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ssrt_pkg::cell_ctrl_t         ctrl_i,
  input  logic                         valid_i,
  input  logic [KEY_W-1:0]             cmp_key_i,
  input  logic [KEY_W-1:0]             new_key_i,
  input  logic [ssrt_pkg::DistW-1:0]   new_dist_i,
  input  logic                         left_lt_i,
  input  logic [KEY_W-1:0]             left_key_i,
  input  logic [ssrt_pkg::DistW-1:0]   left_dist_i,
  input  logic [KEY_W-1:0]             right_key_i,
  input  logic [ssrt_pkg::DistW-1:0]   right_dist_i,
  output logic [KEY_W-1:0]             key_o,
  output logic [ssrt_pkg::DistW-1:0]   dist_o,
  output logic                         lt_o,
  output logic                         eq_o
);

  logic [KEY_W-1:0]           key_q, key_d;
  logic [ssrt_pkg::DistW-1:0] dist_q, dist_d;
  logic                       lt_q, eq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else if (ctrl_i.load) begin
      lt_q <= valid_i && (key_q < cmp_key_i);
      eq_q <= valid_i && (key_q == cmp_key_i);
    end
  end

  always_comb begin
    key_d  = key_q;
    dist_d = dist_q;
    if (ctrl_i.ins && !lt_q) begin
      // the first cell not below the key takes the new entry
      if (left_lt_i) begin
        key_d  = new_key_i;
        dist_d = new_dist_i;
      end else begin
        key_d  = left_key_i;
        dist_d = left_dist_i;
      end
    end else if (ctrl_i.del && !lt_q) begin
      key_d  = right_key_i;
      dist_d = right_dist_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    dist_q <= dist_d;
  end

  assign key_o  = key_q;
  assign dist_o = dist_q;
  assign lt_o   = lt_q;
  assign eq_o   = eq_q;

endmodule

// ===== sv/sorted_sparse_route_table.sv =====
// Sorted sparse route table: a row of CAPACITY cells kept in key order.
// On acceptance every cell latches its compare flags against the key; in the
// execute state, once the output can take a result, the row shifts and the
// result is registered. A new request is accepted only after the previous one
// has left the execute state, so requests do not overlap.
// Reset clears the entry count and cursor at once; entries need no clearing.
module sorted_sparse_route_table #(
  parameter int unsigned CAPACITY  = 64,
  parameter int unsigned CITY_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // cmd[2:0], key_source[18:3], key_dest[34:19], distance[65:35], zero pad
  input  logic [ssrt_pkg::InDataW-1:0]      s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // status[2:0], found[3], out_source[19:4], out_dest[35:20],
  // out_distance[66:36], at_end[67], zero pad
  output logic [ssrt_pkg::OutDataW-1:0]     m_axis_tdata
);

  localparam int unsigned KEY_W = 2 * CITY_BITS;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned DW    = ssrt_pkg::DistW;
  localparam int unsigned PW    = ssrt_pkg::PortCityW;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;

  // incoming request fields
  logic [ssrt_pkg::CmdW-1:0] in_cmd;
  logic [PW-1:0]             in_src, in_dst;
  logic [DW-1:0]             in_dist;
  logic [31:0]               in_src32, in_dst32;
  logic [KEY_W-1:0]          in_key;

  assign in_cmd   = s_axis_tdata[2:0];
  assign in_src   = s_axis_tdata[18:3];
  assign in_dst   = s_axis_tdata[34:19];
  assign in_dist  = s_axis_tdata[65:35];
  assign in_src32 = 32'(in_src);
  assign in_dst32 = 32'(in_dst);
  assign in_key   = {in_src32[CITY_BITS-1:0], in_dst32[CITY_BITS-1:0]};

  logic s_accept, exec_fire;
  assign s_axis_tready = (state_q == S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign exec_fire     = (state_q == S_EXEC) && (!m_axis_tvalid || m_axis_tready);

  logic [ssrt_pkg::CmdW-1:0] cmd_q;
  logic [KEY_W-1:0]          key_q;
  logic [DW-1:0]             dist_q;
  logic [CNT_W-1:0]          count_q, count_d;
  logic [CNT_W-1:0]          cursor_q, cursor_d;

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      cmd_q  <= in_cmd;
      key_q  <= in_key;
      dist_q <= in_dist;
    end
  end

  // cell row
  ssrt_pkg::cell_ctrl_t       ctrl;
  logic [CAPACITY-1:0]        c_lt, c_eq, c_valid;
  logic [KEY_W-1:0]           c_key  [CAPACITY];
  logic [DW-1:0]              c_dist [CAPACITY];
  logic                       ins, del;

  assign ctrl.load = s_accept;
  assign ctrl.ins  = exec_fire && ins;
  assign ctrl.del  = exec_fire && del;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic             left_lt;
    logic [KEY_W-1:0] left_key, right_key;
    logic [DW-1:0]    left_dist, right_dist;

    assign c_valid[i] = (CNT_W'(i) < count_q);

    if (i == 0) begin : g_first
      assign left_lt   = 1'b1;
      assign left_key  = key_q;
      assign left_dist = dist_q;
    end else begin : g_mid
      assign left_lt   = c_lt[i-1];
      assign left_key  = c_key[i-1];
      assign left_dist = c_dist[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_key  = c_key[i];
      assign right_dist = c_dist[i];
    end else begin : g_inner
      assign right_key  = c_key[i+1];
      assign right_dist = c_dist[i+1];
    end

    ssrt_cell #(
      .KEY_W (KEY_W)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .valid_i      (c_valid[i]),
      .cmp_key_i    (in_key),
      .new_key_i    (key_q),
      .new_dist_i   (dist_q),
      .left_lt_i    (left_lt),
      .left_key_i   (left_key),
      .left_dist_i  (left_dist),
      .right_key_i  (right_key),
      .right_dist_i (right_dist),
      .key_o        (c_key[i]),
      .dist_o       (c_dist[i]),
      .lt_o         (c_lt[i]),
      .eq_o         (c_eq[i])
    );
  end

  // command decode
  logic                           hit, is_iter, is_find, found;
  logic [ssrt_pkg::StatusW-1:0]   status;

  assign hit     = |c_eq;
  assign is_find = (cmd_q == ssrt_pkg::CMD_FIND);
  assign is_iter = (cmd_q == ssrt_pkg::CMD_IT_FIRST) || (cmd_q == ssrt_pkg::CMD_IT_NEXT);

  always_comb begin
    status   = ssrt_pkg::ST_OK;
    count_d  = count_q;
    cursor_d = cursor_q;
    ins      = 1'b0;
    del      = 1'b0;
    case (cmd_q)
      ssrt_pkg::CMD_ADD: begin
        if (hit) begin
          status = ssrt_pkg::ST_DUP;
        end else if (count_q >= CNT_W'(CAPACITY)) begin
          status = ssrt_pkg::ST_FULL;
        end else begin
          ins     = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      ssrt_pkg::CMD_REMOVE: begin
        if (count_q == '0) begin
          status = ssrt_pkg::ST_EMPTY;
        end else if (!hit) begin
          status = ssrt_pkg::ST_ABSENT;
        end else begin
          del     = 1'b1;
          count_d = count_q - 1'b1;
        end
      end
      ssrt_pkg::CMD_FIND: begin
        if (!hit) begin
          status = ssrt_pkg::ST_ABSENT;
        end
      end
      ssrt_pkg::CMD_IT_FIRST: begin
        cursor_d = '0;
      end
      ssrt_pkg::CMD_IT_NEXT: begin
        if (cursor_q < count_q) begin
          cursor_d = cursor_q + 1'b1;
        end
      end
      ssrt_pkg::CMD_CLEAR: begin
        count_d  = '0;
        cursor_d = '0;
      end
      default: begin
      end
    endcase
  end

  // select the cell to read: the hit cell for find, the cursor cell for iteration
  logic [CAPACITY-1:0] sel;
  logic                emit;
  assign emit = is_iter && (cursor_d < count_q);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_sel
    assign sel[i] = (is_find && c_eq[i]) || (emit && (cursor_d == CNT_W'(i)));
  end

  logic [KEY_W-1:0] rd_key;
  logic [DW-1:0]    rd_dist;

  always_comb begin
    rd_key  = '0;
    rd_dist = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      rd_key  = rd_key  | (c_key[i]  & {KEY_W{sel[i]}});
      rd_dist = rd_dist | (c_dist[i] & {DW{sel[i]}});
    end
  end

  logic [31:0] rd_src32, rd_dst32;
  logic [PW-1:0] out_src, out_dst;
  logic          at_end;

  assign rd_src32 = 32'(rd_key[KEY_W-1:CITY_BITS]);
  assign rd_dst32 = 32'(rd_key[CITY_BITS-1:0]);
  assign out_src  = emit ? rd_src32[PW-1:0] : '0;
  assign out_dst  = emit ? rd_dst32[PW-1:0] : '0;
  assign found    = emit || (is_find && hit);
  assign at_end   = (cursor_d >= count_d);

  logic [ssrt_pkg::OutDataW-1:0] m_tdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      count_q       <= '0;
      cursor_q      <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (exec_fire) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_accept) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_fire) begin
            count_q  <= count_d;
            cursor_q <= cursor_d;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      m_tdata_q <= {4'b0, at_end, rd_dist, out_dst, out_src, found, status};
    end
  end

  assign m_axis_tdata = m_tdata_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(c_eq))
    else $error("more than one cell matches the key");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> (state_q == S_EXEC))
    else $error("accepted request not executed");

  a_shift_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl.ins && ctrl.del))
    else $error("insert and delete in the same cycle");
`endif

endmodule
